// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the marker frame deframer: the marker
// byte, header layout and the result entry carried from front to back.
// ----------------------------------------------------------------------------
package mfd_pkg;

	// Marker: three '#' bytes in a row
	localparam logic [7:0] MARKER_BYTE = 8'h23;
	localparam logic [1:0] MARKER_LAST = 2'd2;

	// Header byte positions (length, address low/high, type low/high)
	localparam logic [2:0] HDR_LEN     = 3'd0;
	localparam logic [2:0] HDR_ADDR_LO = 3'd1;
	localparam logic [2:0] HDR_ADDR_HI = 3'd2;
	localparam logic [2:0] HDR_TYPE_LO = 3'd3;
	localparam logic [2:0] HDR_TYPE_HI = 3'd4;

	// One result beat as it travels through the queue
	typedef struct packed {
		logic [15:0] msg_type;
		logic [15:0] dest_address;
		logic [7:0]  payload_length;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
	} mfd_entry_t;

	// Queue occupancy seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} mfd_qstat_t;

endpackage

// ===== rtl/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front
// Accepts received bytes, hunts for the marker, collects the header and
// turns payload bytes (or an empty message) into result entries.
// ----------------------------------------------------------------------------
module mfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	input  mfd_pkg::mfd_qstat_t qstat,
	output logic               push,
	output mfd_pkg::mfd_entry_t push_entry
);
	import mfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  marker_count_q, marker_count_d;
	logic [2:0]  header_index_q, header_index_d;
	logic [7:0]  held_length_q, held_length_d;
	logic [15:0] held_address_q, held_address_d;
	logic [15:0] held_type_q, held_type_d;
	logic [7:0]  remaining_q, remaining_d;
	logic        accept;
	logic        is_last;

	// Hold off the link while the queue has no room
	assign rx_stall = qstat.full;
	assign accept   = rx_valid && !rx_stall;
	assign is_last  = (remaining_q <= 8'd1);

	// Classify the byte and work out the next state
	always_comb begin
		phase_d        = phase_q;
		marker_count_d = marker_count_q;
		header_index_d = header_index_q;
		held_length_d  = held_length_q;
		held_address_d = held_address_q;
		held_type_d    = held_type_q;
		remaining_d    = remaining_q;
		push           = 1'b0;
		push_entry     = '0;
		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					case (header_index_q)
						HDR_LEN:     held_length_d = rx_byte;
						HDR_ADDR_LO: held_address_d = {held_address_q[15:8], rx_byte};
						HDR_ADDR_HI: held_address_d = {rx_byte, held_address_q[7:0]};
						HDR_TYPE_LO: held_type_d = {held_type_q[15:8], rx_byte};
						default:     held_type_d = {rx_byte, held_type_q[7:0]};
					endcase
					if (header_index_q >= HDR_TYPE_HI) begin
						header_index_d = '0;
						if (held_length_d == 8'd0) begin
							// Empty message: one beat with no data
							phase_d                   = PH_HUNT;
							remaining_d               = '0;
							push                      = 1'b1;
							push_entry.msg_type       = held_type_d;
							push_entry.dest_address   = held_address_d;
							push_entry.payload_length = held_length_d;
							push_entry.payload_byte   = '0;
							push_entry.byte_valid     = 1'b0;
							push_entry.last           = 1'b1;
						end else begin
							phase_d     = PH_PAYLOAD;
							remaining_d = held_length_d;
						end
					end else begin
						header_index_d = header_index_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					push                      = 1'b1;
					push_entry.msg_type       = held_type_q;
					push_entry.dest_address   = held_address_q;
					push_entry.payload_length = held_length_q;
					push_entry.payload_byte   = rx_byte;
					push_entry.byte_valid     = 1'b1;
					push_entry.last           = is_last;
					if (is_last) begin
						remaining_d = '0;
						phase_d     = PH_HUNT;
					end else begin
						remaining_d = remaining_q - 8'd1;
					end
				end
				default: begin
					// Hunt: count consecutive marker bytes
					phase_d = PH_HUNT;
					if (rx_byte == MARKER_BYTE) begin
						if (marker_count_q == MARKER_LAST) begin
							marker_count_d = '0;
							header_index_d = '0;
							phase_d        = PH_HEADER;
						end else begin
							marker_count_d = marker_count_q + 2'd1;
						end
					end else begin
						marker_count_d = '0;
					end
				end
			endcase
		end
	end

	// Hold the deframing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			marker_count_q <= '0;
			header_index_q <= '0;
			held_length_q  <= '0;
			held_address_q <= '0;
			held_type_q    <= '0;
			remaining_q    <= '0;
		end else begin
			phase_q        <= phase_d;
			marker_count_q <= marker_count_d;
			header_index_q <= header_index_d;
			held_length_q  <= held_length_d;
			held_address_q <= held_address_d;
			held_type_q    <= held_type_d;
			remaining_q    <= remaining_d;
		end
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_index_q <= HDR_TYPE_HI)
		else $error("header index beyond last header byte");

	a_push_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (phase_q == PH_HEADER || phase_q == PH_PAYLOAD))
		else $error("result pushed while hunting for marker");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (remaining_q != 8'd0))
		else $error("payload phase with nothing remaining");

endmodule

// ===== rtl/mfd_queue.sv =====
// ----------------------------------------------------------------------------
// mfd_queue
// Short register queue between the front and back parts, so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module mfd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mfd_pkg::mfd_entry_t push_entry,
	input  logic                pop,
	output mfd_pkg::mfd_entry_t head,
	output mfd_pkg::mfd_qstat_t qstat
);
	import mfd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfd_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ while queue empty");

endmodule

// ===== rtl/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back
// Output register: takes entries from the queue head and presents them
// as result beats, refilling in the cycle the current beat is taken.
// ----------------------------------------------------------------------------
module mfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mfd_pkg::mfd_qstat_t qstat,
	input  mfd_pkg::mfd_entry_t head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output mfd_pkg::mfd_entry_t res_entry
);
	import mfd_pkg::*;

	logic       out_valid_q;
	mfd_entry_t out_entry_q;

	// Refill when the register is empty or its beat leaves now
	assign pop       = !qstat.empty && (!out_valid_q || !res_stall);
	assign res_valid = out_valid_q;
	assign res_entry = out_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load payload without reset
	always_ff @(posedge clk) begin
		if (pop) begin
			out_entry_q <= head;
		end
	end

endmodule

// ===== rtl/marker_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// marker_frame_deframer
// Byte-stream deframer: finds a '###' marker, reads a five-byte header
// (length, address, type) and emits each payload byte tagged with it.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  rx      | rx_valid / rx_stall  | rx_byte
//  res     | res_valid / res_stall| msg_type, dest_address, payload_length,
//          |                      | payload_byte, byte_valid, last
//
// One byte is accepted per cycle while rx_stall is low; each result is
// written into the queue, then loaded into the output register.
// rx_stall rises only while the queue is full, which needs res_stall
// held for QUEUE_DEPTH + 1 result beats.
// Reset returns the front to the marker hunt and empties queue and output.
// ----------------------------------------------------------------------------
module marker_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] msg_type,
	output logic [15:0] dest_address,
	output logic [7:0]  payload_length,
	output logic [7:0]  payload_byte,
	output logic        byte_valid,
	output logic        last
);
	import mfd_pkg::*;

	mfd_qstat_t qstat;
	mfd_entry_t push_entry;
	mfd_entry_t head;
	mfd_entry_t res_entry;
	logic       push;
	logic       pop;

	mfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	mfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	mfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_entry (res_entry)
	);

	// Unpack the result beat onto its ports
	assign msg_type       = res_entry.msg_type;
	assign dest_address   = res_entry.dest_address;
	assign payload_length = res_entry.payload_length;
	assign payload_byte   = res_entry.payload_byte;
	assign byte_valid     = res_entry.byte_valid;
	assign last           = res_entry.last;

endmodule
